>>> rtl/bpfa_pkg.sv
// Shared types, codes and default sizes of the bitmap page frame allocator.
`timescale 1ns / 1ps

package bpfa_pkg;

    // Default map geometry
    localparam int DEF_TOTAL_WORDS    = 1024;
    localparam int DEF_RESERVED_WORDS = 16;
    localparam int DEF_PAGING_WORDS   = 16;
    localparam int DEF_FRAME_SHIFT    = 12;

    // Fixed field widths
    localparam int ADDR_W  = 27;
    localparam int COUNT_W = 15;
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [WORD_W-1:0]  FULL_WORD = {WORD_W{1'b1}};

    // Request codes
    typedef enum logic [1:0] {
        REQ_GEN_ALLOC = 2'd0,
        REQ_PAG_ALLOC = 2'd1,
        REQ_GEN_FREE  = 2'd2,
        REQ_PAG_FREE  = 2'd3
    } t_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_OUTSIDE   = 2'd3
    } t_status;

    // What the bit unit reports on one map word
    typedef struct packed {
        logic              full;
        logic [BIT_W-1:0]  low_bit;
        logic [WORD_W-1:0] set_word;
        logic              bit_set;
        logic [WORD_W-1:0] clr_word;
    } t_word_info;

endpackage

>>> rtl/bpfa_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bpfa_bit_ops.sv
// Bit unit: lowest clear bit, set and clear of one map word.
`timescale 1ns / 1ps

module bpfa_bit_ops (
    input  logic [bpfa_pkg::WORD_W-1:0] i_word,
    input  logic [bpfa_pkg::BIT_W-1:0]  i_bit,
    output bpfa_pkg::t_word_info        o_info
);

    logic [bpfa_pkg::WORD_W-1:0] inv;
    logic [bpfa_pkg::WORD_W-1:0] low_hot;
    logic [bpfa_pkg::WORD_W-1:0] sel_hot;
    logic [bpfa_pkg::BIT_W-1:0]  low_bit;

    // Isolate the lowest zero bit as a one-hot mask
    assign inv     = ~i_word;
    assign low_hot = inv & (~inv + bpfa_pkg::WORD_W'(1));
    assign sel_hot = bpfa_pkg::WORD_W'(1) << i_bit;

    // Encode the one-hot mask
    always_comb begin
        low_bit = '0;
        for (int b = 0; b < bpfa_pkg::WORD_W; b++) begin
            if (low_hot[b]) begin
                low_bit = low_bit | bpfa_pkg::BIT_W'(b);
            end
        end
    end

    assign o_info.full     = (i_word == bpfa_pkg::FULL_WORD);
    assign o_info.low_bit  = low_bit;
    assign o_info.set_word = i_word | low_hot;
    assign o_info.bit_set  = |(i_word & sel_hot);
    assign o_info.clr_word = i_word & ~sel_hot;

endmodule

>>> rtl/bitmap_page_frame_allocator_core.sv
// Bitmap page frame allocator: used-bit map in RAM, next-fit general scan.
// After reset the block sweeps the map to zero, one word per cycle, and holds
// o_in_stall high until the sweep is done. One request is worked at a time.
// A free goes through an address check, a map read and write back, and a
// result load. An allocation reads the map one word per cycle from its start
// word until a word read has a clear bit; a general allocation usually hits
// its hint word at once, and a failed one reads the whole region. The next
// request is taken while the last result still waits at the output.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_core #(
    parameter int TOTAL_WORDS    = bpfa_pkg::DEF_TOTAL_WORDS,
    parameter int RESERVED_WORDS = bpfa_pkg::DEF_RESERVED_WORDS,
    parameter int PAGING_WORDS   = bpfa_pkg::DEF_PAGING_WORDS,
    parameter int FRAME_SHIFT    = bpfa_pkg::DEF_FRAME_SHIFT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_req_type,
    input  logic [bpfa_pkg::ADDR_W-1:0]  i_frame_address,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bpfa_pkg::ADDR_W-1:0]  o_result_address,
    output logic [1:0]                   o_status,
    output logic [bpfa_pkg::COUNT_W-1:0] o_free_frames
);

    // Region layout
    localparam int WW       = $clog2(TOTAL_WORDS);
    localparam int RES_W    = (RESERVED_WORDS > TOTAL_WORDS) ? TOTAL_WORDS : RESERVED_WORDS;
    localparam int LEFT_W   = TOTAL_WORDS - RES_W;
    localparam int PAG_W    = (PAGING_WORDS > LEFT_W) ? LEFT_W : PAGING_WORDS;
    localparam int GEN_BASE = RES_W + PAG_W;
    localparam int GEN_W    = TOTAL_WORDS - GEN_BASE;
    localparam int GEN_FRAMES = GEN_W * bpfa_pkg::WORD_W;

    localparam logic [WW-1:0] LAST_WORD  = WW'(TOTAL_WORDS - 1);
    localparam logic [WW-1:0] RES_A      = WW'(RES_W);
    localparam logic [WW-1:0] GEN_BASE_A = WW'(GEN_BASE);
    localparam logic [WW-1:0] GEN_LAST   = WW'((GEN_W > 0) ? GEN_W - 1 : 0);
    localparam logic [WW-1:0] PAG_LAST   = WW'((PAG_W > 0) ? PAG_W - 1 : 0);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FREE  = 5'b01000,
        S_PUSH  = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [WW-1:0]                r_clr, n_clr;
    logic [WW-1:0]                r_hint, n_hint;
    logic [bpfa_pkg::COUNT_W-1:0] r_used, n_used;
    logic [WW-1:0]                r_idx, n_idx;
    logic [WW-1:0]                r_addr, n_addr;
    logic [WW-1:0]                r_left, n_left;
    logic                         r_gen, n_gen;
    logic [bpfa_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic [bpfa_pkg::ADDR_W-1:0]  r_res_addr, n_res_addr;
    bpfa_pkg::t_status            r_res_status, n_res_status;
    logic                         r_out_valid, n_out_valid;
    logic [bpfa_pkg::ADDR_W-1:0]  r_out_addr, n_out_addr;
    bpfa_pkg::t_status            r_out_status, n_out_status;
    logic [bpfa_pkg::COUNT_W-1:0] r_out_free, n_out_free;

    logic                         ram_we;
    logic [WW-1:0]                ram_waddr;
    logic [bpfa_pkg::WORD_W-1:0]  ram_wdata;
    logic [WW-1:0]                ram_raddr;
    logic [bpfa_pkg::WORD_W-1:0]  ram_rdata;
    bpfa_pkg::t_word_info         info;

    logic                         in_xfer;
    logic                         out_free;
    logic [31:0]                  req_word;
    logic                         addr_ok;
    logic                         wrap;
    logic [bpfa_pkg::COUNT_W-1:0] free_now;

    // Used-bit map
    bpfa_ram #(
        .WIDTH (bpfa_pkg::WORD_W),
        .DEPTH (TOTAL_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpfa_bit_ops u_bits (
        .i_word (ram_rdata),
        .i_bit  (r_bit),
        .o_info (info)
    );

    // Handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Free request decode
    assign req_word = 32'(i_frame_address >> (FRAME_SHIFT + bpfa_pkg::BIT_W));
    assign addr_ok  = (req_word < 32'(TOTAL_WORDS)) &&
                      ((bpfa_pkg::t_req'(i_req_type) != bpfa_pkg::REQ_GEN_FREE) ||
                       (req_word >= 32'(GEN_BASE)));

    // Scan wrap point
    assign wrap = r_gen ? (r_idx == GEN_LAST) : (r_idx == PAG_LAST);

    // Free general frames
    assign free_now = (32'(r_used) >= 32'(GEN_FRAMES)) ? '0
                    : bpfa_pkg::COUNT_W'(32'(GEN_FRAMES) - 32'(r_used));

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_hint       = r_hint;
        n_used       = r_used;
        n_idx        = r_idx;
        n_addr       = r_addr;
        n_left       = r_left;
        n_gen        = r_gen;
        n_bit        = r_bit;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_free   = r_out_free;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = info.set_word;
        ram_raddr    = r_addr;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + WW'(1);
                if (r_clr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_xfer) begin
                    n_res_addr = '0;
                    case (bpfa_pkg::t_req'(i_req_type))
                        bpfa_pkg::REQ_GEN_ALLOC: begin
                            n_gen = 1'b1;
                            if (GEN_W == 0) begin
                                n_res_status = bpfa_pkg::ST_NO_FREE;
                                n_state      = S_PUSH;
                            end else begin
                                n_idx     = r_hint;
                                n_addr    = GEN_BASE_A + r_hint;
                                n_left    = GEN_LAST;
                                ram_raddr = GEN_BASE_A + r_hint;
                                n_state   = S_SCAN;
                            end
                        end
                        bpfa_pkg::REQ_PAG_ALLOC: begin
                            n_gen = 1'b0;
                            if (PAG_W == 0) begin
                                n_res_status = bpfa_pkg::ST_NO_FREE;
                                n_state      = S_PUSH;
                            end else begin
                                n_idx     = '0;
                                n_addr    = RES_A;
                                n_left    = PAG_LAST;
                                ram_raddr = RES_A;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            n_gen     = (bpfa_pkg::t_req'(i_req_type) ==
                                         bpfa_pkg::REQ_GEN_FREE);
                            n_bit     = i_frame_address[FRAME_SHIFT +: bpfa_pkg::BIT_W];
                            n_addr    = req_word[WW-1:0];
                            ram_raddr = req_word[WW-1:0];
                            if (!addr_ok) begin
                                n_res_status = bpfa_pkg::ST_OUTSIDE;
                                n_state      = S_PUSH;
                            end else begin
                                n_state = S_FREE;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (!info.full) begin
                    // Claim the lowest clear bit of this word
                    ram_we       = 1'b1;
                    ram_wdata    = info.set_word;
                    n_res_addr   = bpfa_pkg::ADDR_W'(64'({r_addr, info.low_bit}) << FRAME_SHIFT);
                    n_res_status = bpfa_pkg::ST_OK;
                    if (r_gen) begin
                        n_hint = r_idx;
                        if (r_used != bpfa_pkg::COUNT_MAX) begin
                            n_used = r_used + bpfa_pkg::COUNT_W'(1);
                        end
                    end
                    n_state = S_PUSH;
                end else if (r_left == '0) begin
                    n_res_status = bpfa_pkg::ST_NO_FREE;
                    n_state      = S_PUSH;
                end else begin
                    // Word full: read the next one, wrapping in the region
                    n_idx     = wrap ? '0 : r_idx + WW'(1);
                    n_addr    = wrap ? (r_gen ? GEN_BASE_A : RES_A) : r_addr + WW'(1);
                    ram_raddr = n_addr;
                    n_left    = r_left - WW'(1);
                end
            end

            S_FREE: begin
                if (!info.bit_set) begin
                    n_res_status = bpfa_pkg::ST_NOT_ALLOC;
                end else begin
                    ram_we       = 1'b1;
                    ram_wdata    = info.clr_word;
                    n_res_status = bpfa_pkg::ST_OK;
                    if (r_gen) begin
                        n_hint = r_addr - GEN_BASE_A;
                        if (r_used != '0) begin
                            n_used = r_used - bpfa_pkg::COUNT_W'(1);
                        end
                    end
                end
                n_state = S_PUSH;
            end

            S_PUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_out_free   = free_now;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hint      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // Work and result registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_addr       <= n_addr;
        r_left       <= n_left;
        r_gen        <= n_gen;
        r_bit        <= n_bit;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_free   <= n_out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;
    assign o_free_frames    = r_out_free;

endmodule
